// ===== sv/dual_average_momentum_sizer_defines.svh =====
// ---------------------------------------------------------------------------
// dual_average_momentum_sizer_defines.svh
// Assertion macros shared by the checker of the momentum sizer.
// ---------------------------------------------------------------------------
`ifndef DUAL_AVERAGE_MOMENTUM_SIZER_DEFINES_SVH
`define DUAL_AVERAGE_MOMENTUM_SIZER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define DAMSZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dual_average_momentum_sizer: same-cycle check failed");

// next-cycle implication, quiet while reset is held
`define DAMSZ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dual_average_momentum_sizer: next-cycle check failed");

`endif

// ===== sv/damsz_pkg.sv =====
// ---------------------------------------------------------------------------
// damsz_pkg
// Types, widths and constants shared by the momentum sizer modules.
// ---------------------------------------------------------------------------
package damsz_pkg;

    // field widths
    localparam int PRICE_W   = 16;
    localparam int MID_W     = 17;
    localparam int UNITS_W   = 24;
    localparam int CASH_W    = 40;
    localparam int THR_W     = 16;
    localparam int QTY_W     = 6;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // threshold fraction bits and quotient width of the strength divider
    localparam int Q_FRAC    = 16;
    localparam int Q_BITS    = 8;
    localparam int DIV_CNT_W = 3;

    // signed width of position and trade arithmetic
    localparam int POS_W = UNITS_W + 2;

    localparam int STRENGTH_SCALE = 100;
    localparam int TARGET_CAP     = 250;
    localparam int QTY_CAP        = 50;
    localparam int QTY_MIN        = 10;

    // register reset values
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = 16'd328;
    localparam logic [UNITS_W-1:0] INIT_UNITS_RST = 24'd0;
    localparam logic [PRICE_W-1:0] BUY_CAP_RST    = 16'd12000;
    localparam logic [PRICE_W-1:0] SELL_FLOOR_RST = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_INIT_UNITS = 2'd1,
        CFG_BUY_CAP    = 2'd2,
        CFG_SELL_FLOOR = 2'd3
    } cfg_index_t;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_SCALE,
        S_DIFF,
        S_PPLO,
        S_PPHI,
        S_TDEN,
        S_CMP,
        S_NMUL,
        S_NADD,
        S_DIV,
        S_TRADE,
        S_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic push;
        logic scale;
        logic diff;
        logic pp_lo;
        logic pp_hi;
        logic tden;
        logic cmp;
        logic n_mul;
        logic n_add;
        logic div_step;
        logic trade;
        logic check;
        logic res_none;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic book_valid;
        logic windows_full;
        logic no_signal;
        logic saturate;
        logic out_free;
    } status_t;

endpackage

// ===== sv/damsz_ctrl.sv =====
// ---------------------------------------------------------------------------
// damsz_ctrl
// Sequencer: steps the datapath through push, compare, divide and sizing.
// ---------------------------------------------------------------------------
module damsz_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  damsz_pkg::status_t status,
    output damsz_pkg::cmd_t    cmd
);

    damsz_pkg::state_t state_reg;
    damsz_pkg::state_t state_next;
    logic [damsz_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [damsz_pkg::DIV_CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= damsz_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            damsz_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.book_valid)
                    begin
                        state_next = damsz_pkg::S_PUSH;
                    end
                    else
                    begin
                        cmd.res_none = 1'b1;
                        state_next   = damsz_pkg::S_OUT;
                    end
                end
            end
            damsz_pkg::S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = damsz_pkg::S_SCALE;
            end
            damsz_pkg::S_SCALE:
            begin
                if (status.windows_full)
                begin
                    cmd.scale  = 1'b1;
                    state_next = damsz_pkg::S_DIFF;
                end
                else
                begin
                    cmd.res_none = 1'b1;
                    state_next   = damsz_pkg::S_OUT;
                end
            end
            damsz_pkg::S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = damsz_pkg::S_PPLO;
            end
            damsz_pkg::S_PPLO:
            begin
                cmd.pp_lo  = 1'b1;
                state_next = damsz_pkg::S_PPHI;
            end
            damsz_pkg::S_PPHI:
            begin
                cmd.pp_hi  = 1'b1;
                state_next = damsz_pkg::S_TDEN;
            end
            damsz_pkg::S_TDEN:
            begin
                cmd.tden   = 1'b1;
                state_next = damsz_pkg::S_CMP;
            end
            damsz_pkg::S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = damsz_pkg::S_NMUL;
            end
            damsz_pkg::S_NMUL:
            begin
                // skip the divider when the target is already settled
                if (status.no_signal || status.saturate)
                begin
                    state_next = damsz_pkg::S_TRADE;
                end
                else
                begin
                    cmd.n_mul  = 1'b1;
                    state_next = damsz_pkg::S_NADD;
                end
            end
            damsz_pkg::S_NADD:
            begin
                cmd.n_add  = 1'b1;
                cnt_next   = '0;
                state_next = damsz_pkg::S_DIV;
            end
            damsz_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == damsz_pkg::DIV_CNT_W'(damsz_pkg::Q_BITS - 1))
                begin
                    state_next = damsz_pkg::S_TRADE;
                end
            end
            damsz_pkg::S_TRADE:
            begin
                cmd.trade  = 1'b1;
                state_next = damsz_pkg::S_CHECK;
            end
            damsz_pkg::S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = damsz_pkg::S_OUT;
            end
            damsz_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = damsz_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = damsz_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/damsz_dp.sv =====
// ---------------------------------------------------------------------------
// damsz_dp
// Datapath: config registers, mid windows, divergence arithmetic, divider,
// order sizing and the output register.
// ---------------------------------------------------------------------------
module damsz_dp #(
    parameter int SHORT_WINDOW = 16,
    parameter int LONG_WINDOW  = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [damsz_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [damsz_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_book_valid,
    input  logic [damsz_pkg::PRICE_W-1:0]        in_bid,
    input  logic [damsz_pkg::PRICE_W-1:0]        in_ask,
    input  logic [damsz_pkg::UNITS_W-1:0]        in_units,
    input  logic [damsz_pkg::CASH_W-1:0]         in_cash,
    input  damsz_pkg::cmd_t                      cmd,
    output damsz_pkg::status_t                   status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 out_order_valid,
    output logic                                 out_side,
    output logic [damsz_pkg::QTY_W-1:0]          out_qty,
    output logic [damsz_pkg::PRICE_W-1:0]        out_price
);

    localparam int MID_W  = damsz_pkg::MID_W;
    localparam int SH_W   = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
    localparam int LH_W   = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
    localparam int SF_W   = $clog2(SHORT_WINDOW + 1);
    localparam int LF_W   = $clog2(LONG_WINDOW + 1);
    localparam int SSUM_W = MID_W + $clog2(SHORT_WINDOW);
    localparam int LSUM_W = MID_W + $clog2(LONG_WINDOW);
    localparam int PROD_W = MID_W + $clog2(SHORT_WINDOW) + $clog2(LONG_WINDOW);
    localparam int LO_W   = (PROD_W + 1) / 2;
    localparam int PP_W   = damsz_pkg::THR_W + LO_W;
    localparam int TDEN_W = PROD_W + damsz_pkg::Q_FRAC;
    localparam int DIV_W  = TDEN_W + damsz_pkg::Q_BITS;
    localparam int POS_W  = damsz_pkg::POS_W;
    localparam int QTY_W  = damsz_pkg::QTY_W;
    localparam int COST_W = QTY_W + damsz_pkg::PRICE_W;

    // configuration
    logic [damsz_pkg::THR_W-1:0]   thr_reg;
    logic [damsz_pkg::UNITS_W-1:0] init_units_reg;
    logic [damsz_pkg::PRICE_W-1:0] buy_cap_reg;
    logic [damsz_pkg::PRICE_W-1:0] sell_floor_reg;

    // window state
    logic [MID_W-1:0]  short_ring [SHORT_WINDOW];
    logic [MID_W-1:0]  long_ring  [LONG_WINDOW];
    logic [SH_W-1:0]   s_head_reg;
    logic [LH_W-1:0]   l_head_reg;
    logic [SF_W-1:0]   s_fill_reg;
    logic [LF_W-1:0]   l_fill_reg;
    logic [SSUM_W-1:0] s_sum_reg;
    logic [LSUM_W-1:0] l_sum_reg;
    logic              s_full;
    logic              l_full;

    // captured item
    logic [MID_W-1:0]              mid_reg;
    logic [MID_W-1:0]              s_old_reg;
    logic [MID_W-1:0]              l_old_reg;
    logic [damsz_pkg::UNITS_W-1:0] units_reg;
    logic [damsz_pkg::CASH_W-1:0]  cash_reg;

    // divergence arithmetic
    logic [PROD_W-1:0] a_reg;
    logic [PROD_W-1:0] b_reg;
    logic [PROD_W-1:0] mag_reg;
    logic              neg_reg;
    logic [LO_W-1:0]   mul_b;
    logic [PP_W-1:0]   mul_p;
    logic [PP_W-1:0]   pp_lo_reg;
    logic [PP_W-1:0]   pp_hi_reg;
    logic [TDEN_W-1:0] tden_reg;
    logic [TDEN_W-1:0] lhs;
    logic [TDEN_W+2:0] tden5;
    logic              no_sig_reg;
    logic              sat_reg;

    // divider
    logic [DIV_W-1:0]               n_reg;
    logic [DIV_W-1:0]               d_reg;
    logic [damsz_pkg::Q_BITS-1:0]   q_reg;
    logic                           div_ge;

    // sizing
    logic [damsz_pkg::Q_BITS-1:0] t_mag;
    logic signed [POS_W-1:0]      position;
    logic signed [POS_W-1:0]      target;
    logic signed [POS_W-1:0]      delta;
    logic [POS_W-1:0]             delta_abs;
    logic [QTY_W-1:0]             qty_next;
    logic                         buy_next;
    logic [QTY_W-1:0]             qty_reg;
    logic                         buy_reg;
    logic [COST_W-1:0]            cost;

    // result and output stage
    logic                          res_valid_reg;
    logic                          res_side_reg;
    logic [QTY_W-1:0]              res_qty_reg;
    logic [damsz_pkg::PRICE_W-1:0] res_price_reg;
    logic                          out_valid_reg;
    logic                          out_order_reg;
    logic                          out_side_reg;
    logic [QTY_W-1:0]              out_qty_reg;
    logic [damsz_pkg::PRICE_W-1:0] out_price_reg;

    assign s_full = (s_fill_reg == SF_W'(SHORT_WINDOW));
    assign l_full = (l_fill_reg == LF_W'(LONG_WINDOW));

    assign mul_b = cmd.pp_hi ? LO_W'(b_reg[PROD_W-1:LO_W]) : b_reg[LO_W-1:0];
    assign mul_p = PP_W'(thr_reg) * PP_W'(mul_b);

    assign lhs    = {mag_reg, {damsz_pkg::Q_FRAC{1'b0}}};
    assign tden5  = {tden_reg, 2'b00} + (TDEN_W + 3)'(tden_reg);
    assign div_ge = (n_reg >= d_reg);

    always_comb
    begin
        if (no_sig_reg)
        begin
            t_mag = '0;
        end
        else if (sat_reg || (q_reg > damsz_pkg::Q_BITS'(damsz_pkg::TARGET_CAP)))
        begin
            t_mag = damsz_pkg::Q_BITS'(damsz_pkg::TARGET_CAP);
        end
        else
        begin
            t_mag = q_reg;
        end
    end

    assign position = $signed({2'b00, units_reg}) - $signed({2'b00, init_units_reg});
    assign target   = neg_reg ? -$signed(POS_W'(t_mag)) : $signed(POS_W'(t_mag));
    assign delta    = target - position;
    assign delta_abs = (delta < 0) ? POS_W'(-delta) : POS_W'(delta);

    always_comb
    begin
        buy_next = (delta > 0);
        if (delta_abs > POS_W'(damsz_pkg::QTY_CAP))
        begin
            qty_next = QTY_W'(damsz_pkg::QTY_CAP);
        end
        else
        begin
            qty_next = delta_abs[QTY_W-1:0];
        end
    end

    assign cost = COST_W'(qty_reg) * COST_W'(buy_cap_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= damsz_pkg::THRESHOLD_RST;
            init_units_reg <= damsz_pkg::INIT_UNITS_RST;
            buy_cap_reg    <= damsz_pkg::BUY_CAP_RST;
            sell_floor_reg <= damsz_pkg::SELL_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (damsz_pkg::cfg_index_t'(cfg_index))
                damsz_pkg::CFG_THRESHOLD:  thr_reg        <= cfg_data[damsz_pkg::THR_W-1:0];
                damsz_pkg::CFG_INIT_UNITS: init_units_reg <= cfg_data[damsz_pkg::UNITS_W-1:0];
                damsz_pkg::CFG_BUY_CAP:    buy_cap_reg    <= cfg_data[damsz_pkg::PRICE_W-1:0];
                damsz_pkg::CFG_SELL_FLOOR: sell_floor_reg <= cfg_data[damsz_pkg::PRICE_W-1:0];
                default:                   thr_reg        <= thr_reg;
            endcase
        end
    end

    // window control: heads, fills, running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_head_reg <= '0;
            l_head_reg <= '0;
            s_fill_reg <= '0;
            l_fill_reg <= '0;
            s_sum_reg  <= '0;
            l_sum_reg  <= '0;
        end
        else if (cmd.push)
        begin
            s_sum_reg <= s_sum_reg - (s_full ? SSUM_W'(s_old_reg) : '0) + SSUM_W'(mid_reg);
            l_sum_reg <= l_sum_reg - (l_full ? LSUM_W'(l_old_reg) : '0) + LSUM_W'(mid_reg);
            if (!s_full)
            begin
                s_fill_reg <= s_fill_reg + 1'b1;
            end
            if (!l_full)
            begin
                l_fill_reg <= l_fill_reg + 1'b1;
            end
            s_head_reg <= (s_head_reg == SH_W'(SHORT_WINDOW - 1)) ? '0 : s_head_reg + 1'b1;
            l_head_reg <= (l_head_reg == LH_W'(LONG_WINDOW - 1)) ? '0 : l_head_reg + 1'b1;
        end
    end

    // window memories: read the oldest entry on capture, overwrite it on push
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_old_reg <= short_ring[s_head_reg];
            l_old_reg <= long_ring[l_head_reg];
        end
        if (cmd.push)
        begin
            short_ring[s_head_reg] <= mid_reg;
            long_ring[l_head_reg]  <= mid_reg;
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mid_reg   <= MID_W'(in_bid) + MID_W'(in_ask);
            units_reg <= in_units;
            cash_reg  <= in_cash;
        end
        if (cmd.scale)
        begin
            a_reg <= PROD_W'(s_sum_reg) * PROD_W'(LONG_WINDOW);
            b_reg <= PROD_W'(l_sum_reg) * PROD_W'(SHORT_WINDOW);
        end
        if (cmd.diff)
        begin
            neg_reg <= (a_reg < b_reg);
            mag_reg <= (a_reg < b_reg) ? (b_reg - a_reg) : (a_reg - b_reg);
        end
        if (cmd.pp_lo)
        begin
            pp_lo_reg <= mul_p;
        end
        if (cmd.pp_hi)
        begin
            pp_hi_reg <= mul_p;
        end
        if (cmd.tden)
        begin
            tden_reg <= TDEN_W'(pp_lo_reg) + (TDEN_W'(pp_hi_reg) << LO_W);
        end
        if (cmd.cmp)
        begin
            no_sig_reg <= (b_reg == '0) || (lhs <= tden_reg);
            sat_reg    <= ((TDEN_W + 3)'(lhs) >= tden5);
        end
        if (cmd.n_mul)
        begin
            n_reg <= DIV_W'(lhs) * DIV_W'(damsz_pkg::STRENGTH_SCALE);
        end
        if (cmd.n_add)
        begin
            n_reg <= n_reg + DIV_W'(tden_reg);
            d_reg <= DIV_W'(tden_reg) << damsz_pkg::Q_BITS;
            q_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                n_reg <= n_reg - d_reg;
            end
            d_reg <= d_reg >> 1;
            q_reg <= {q_reg[damsz_pkg::Q_BITS-2:0], div_ge};
        end
        if (cmd.trade)
        begin
            qty_reg <= qty_next;
            buy_reg <= buy_next;
        end
        if (cmd.res_none)
        begin
            res_valid_reg <= 1'b0;
            res_side_reg  <= 1'b0;
            res_qty_reg   <= '0;
            res_price_reg <= '0;
        end
        else if (cmd.check)
        begin
            // drop small trades, a buy short of cash, a sell short of units
            if (qty_reg < QTY_W'(damsz_pkg::QTY_MIN))
            begin
                res_valid_reg <= 1'b0;
                res_side_reg  <= 1'b0;
                res_qty_reg   <= '0;
                res_price_reg <= '0;
            end
            else if (buy_reg && (cash_reg > damsz_pkg::CASH_W'(cost)))
            begin
                res_valid_reg <= 1'b1;
                res_side_reg  <= damsz_pkg::SIDE_BUY;
                res_qty_reg   <= qty_reg;
                res_price_reg <= buy_cap_reg;
            end
            else if (!buy_reg && (units_reg >= damsz_pkg::UNITS_W'(qty_reg)))
            begin
                res_valid_reg <= 1'b1;
                res_side_reg  <= damsz_pkg::SIDE_SELL;
                res_qty_reg   <= qty_reg;
                res_price_reg <= sell_floor_reg;
            end
            else
            begin
                res_valid_reg <= 1'b0;
                res_side_reg  <= 1'b0;
                res_qty_reg   <= '0;
                res_price_reg <= '0;
            end
        end
        if (cmd.load_out)
        begin
            out_order_reg <= res_valid_reg;
            out_side_reg  <= res_side_reg;
            out_qty_reg   <= res_qty_reg;
            out_price_reg <= res_price_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.book_valid   = in_book_valid;
    assign status.windows_full = s_full && l_full;
    assign status.no_signal    = no_sig_reg;
    assign status.saturate     = sat_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_order_valid = out_order_reg;
    assign out_side        = out_side_reg;
    assign out_qty         = out_qty_reg;
    assign out_price       = out_price_reg;

endmodule

// ===== sv/dual_average_momentum_sizer.sv =====
// ---------------------------------------------------------------------------
// dual_average_momentum_sizer
// Dual moving-average crossover position sizer for a market-making agent.
// ---------------------------------------------------------------------------
//
//  channel   direction  words                          fields (low bit up)
//  s_axis    in         one book update per word       see port comments
//  m_axis    out        exactly one word per update    see port comments
//  cfg       in         register write, no read-back   0 threshold_q16,
//                                                      1 initial_units,
//                                                      2 buy_cap_cents,
//                                                      3 sell_floor_cents
//
//  Paths: an update with an invalid book ends after its capture and one with
//  unfilled windows after its push; a full update skips the divider when the
//  target is zero or saturated, else runs the 8-step restoring divider.
//  The divider (one quotient bit a cycle) and the split threshold multiply
//  set the long path; one update is in flight at a time.
//  Reset: rst_n clears control, sums, fills, heads and the registers to their
//  defaults; the window memories start unwritten and need no clearing pass.
//  Stalls: a finished order sits in the output register, so the next update
//  is taken while m_axis is held; only the hand-off of a second order waits.
//
module dual_average_momentum_sizer #(
    parameter int SHORT_WINDOW = 16,
    parameter int LONG_WINDOW  = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [damsz_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [damsz_pkg::CFG_W-1:0]            cfg_data,
    // book update stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // best_bid_cents[15:0], best_ask_cents[31:16], units_held[55:32],
    // cash_cents[95:56]
    input  logic [damsz_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // book_valid[0]
    input  logic                                   s_axis_tuser,
    // order stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // order_quantity[5:0], order_price_cents[21:6], zero fill [23:22]
    output logic [damsz_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // order_valid[0], order_side[1]
    output logic [damsz_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    damsz_pkg::cmd_t    cmd;
    damsz_pkg::status_t status;

    logic                          order_valid;
    logic                          order_side;
    logic [damsz_pkg::QTY_W-1:0]   order_qty;
    logic [damsz_pkg::PRICE_W-1:0] order_price;

    // sequencer: one update at a time, accept only from idle
    damsz_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: windows, divergence test, divider, sizing, output register
    damsz_dp #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_book_valid   (s_axis_tuser),
        .in_bid          (s_axis_tdata[15:0]),
        .in_ask          (s_axis_tdata[31:16]),
        .in_units        (s_axis_tdata[55:32]),
        .in_cash         (s_axis_tdata[95:56]),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_order_valid (order_valid),
        .out_side        (order_side),
        .out_qty         (order_qty),
        .out_price       (order_price)
    );

    // pack the order word; pad the data to whole bytes
    assign m_axis_tdata = {2'b00, order_price, order_qty};
    assign m_axis_tuser = {order_side, order_valid};

endmodule

// ===== sv/damsz_chk.sv =====
// ---------------------------------------------------------------------------
// damsz_chk
// Port-level checker for the momentum sizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "dual_average_momentum_sizer_defines.svh"

module damsz_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [damsz_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic [damsz_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    // a held order word keeps its contents
    `DAMSZ_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // no order means every field reads zero
    `DAMSZ_ASSERT_IMP(a_no_order_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0 && !m_axis_tuser[1])

    // an emitted order carries a quantity in the tradable band
    `DAMSZ_ASSERT_IMP(a_qty_band, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[5:0] >= damsz_pkg::QTY_W'(damsz_pkg::QTY_MIN) && m_axis_tdata[5:0] <= damsz_pkg::QTY_W'(damsz_pkg::QTY_CAP))

    // one update at a time: ready drops right after an accept
    `DAMSZ_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind dual_average_momentum_sizer damsz_chk u_damsz_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual moving-average momentum sizer. A short
// table of book updates (reset state, window fill, zero average, clamps,
// cash and unit checks, register extremes) runs first. Random phases follow:
// price walks with trends, noise and invalid books under changing register
// settings. Every order word is checked field by field against the scripted
// order or a local model of the sizer.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHORT_LEN   = 16;
    localparam int LONG_LEN    = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 140;   // valid book words per random phase

    // one book update as the sizer sees it
    typedef struct packed {
        logic        book_valid;
        logic [39:0] cash;
        logic [23:0] units;
        logic [15:0] ask;
        logic [15:0] bid;
    } book_update_t;

    // one order word
    typedef struct packed {
        logic        valid;
        logic        side;
        logic [5:0]  qty;
        logic [15:0] price;
    } order_t;

    // row of the directed script: optional register write, then a book word
    typedef struct {
        logic                  cfg_en;
        damsz_pkg::cfg_index_t cfg_idx;
        logic [23:0]           cfg_val;
        book_update_t          bk;
        int                    reps;
        logic                  typed;
        order_t                want;
    } script_row_t;

    localparam order_t NO_ORDER = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_we = 1'b0;
    logic [damsz_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [damsz_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [damsz_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [damsz_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [damsz_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

    dual_average_momentum_sizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Sizer model: doubled mids in two rings with running totals
    // ---------------------------------------------------------------------
    logic [16:0]        short_mids [SHORT_LEN];
    logic [16:0]        long_mids  [LONG_LEN];
    longint unsigned    short_total = 0;
    longint unsigned    long_total  = 0;
    int                 short_count = 0;
    int                 long_count  = 0;
    int                 short_head  = 0;
    int                 long_head   = 0;

    logic [15:0] thr_q16    = damsz_pkg::THRESHOLD_RST;
    logic [23:0] init_units = damsz_pkg::INIT_UNITS_RST;
    logic [15:0] buy_cap    = damsz_pkg::BUY_CAP_RST;
    logic [15:0] sell_floor = damsz_pkg::SELL_FLOOR_RST;

    order_t      orders_due [$];    // order words still owed by the sizer
    int          err_count = 0;
    int          cycle_count = 0;
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;

    // price walk state for the random phases
    int          walk_mid = 10000;
    int          drift = 0;
    int          drift_left = 0;

    // Signed target position, -250..250, from the two window totals.
    // Compare the averages by cross-multiplying so no division is needed
    // until the strength ratio itself.
    function automatic longint crossover_target();
        longint unsigned lead;
        longint unsigned lag;
        longint unsigned gap;
        longint unsigned scaled;
        longint unsigned bar;
        longint unsigned t;
        logic            falling;
        lead = short_total * LONG_LEN;
        lag  = long_total * SHORT_LEN;
        if (lag == 0)
            return 0;           // all mids zero: no divergence
        falling = lead < lag;
        gap     = falling ? lag - lead : lead - lag;
        scaled  = gap << 16;
        bar     = longint'(thr_q16) * lag;
        if (scaled <= bar)
            return 0;
        if (scaled >= 5 * bar)
            t = 250;
        else
        begin
            // round half away from zero
            t = (100 * scaled + bar) / (2 * bar);
            if (t > 250)
                t = 250;
        end
        return falling ? -longint'(t) : longint'(t);
    endfunction

    // Advance the windows with one book word and return the order it causes.
    function automatic order_t size_order(book_update_t bk);
        order_t          res;
        logic [16:0]     mid2;
        longint          delta;
        longint unsigned qty;
        res = NO_ORDER;
        if (!bk.book_valid)
            return res;
        mid2 = bk.bid + bk.ask;
        if (short_count == SHORT_LEN)
            short_total -= short_mids[short_head];
        else
            short_count++;
        short_mids[short_head] = mid2;
        short_total += mid2;
        short_head = (short_head + 1) % SHORT_LEN;
        if (long_count == LONG_LEN)
            long_total -= long_mids[long_head];
        else
            long_count++;
        long_mids[long_head] = mid2;
        long_total += mid2;
        long_head = (long_head + 1) % LONG_LEN;
        if (short_count < SHORT_LEN || long_count < LONG_LEN)
            return res;
        delta = crossover_target() - (longint'(bk.units) - longint'(init_units));
        if (delta > 50)
            delta = 50;
        if (delta < -50)
            delta = -50;
        qty = (delta < 0) ? -delta : delta;
        if (qty < 10)
            return res;
        if (delta > 0)
        begin
            // buys must be strictly covered at the cap price
            if (bk.cash > qty * buy_cap)
            begin
                res.valid = 1'b1;
                res.side  = damsz_pkg::SIDE_BUY;
                res.qty   = qty[5:0];
                res.price = buy_cap;
            end
        end
        else if (bk.units >= qty)
        begin
            res.valid = 1'b1;
            res.side  = damsz_pkg::SIDE_SELL;
            res.qty   = qty[5:0];
            res.price = sell_floor;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Order sink: random back-pressure, compare each accepted word
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        order_t got;
        order_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.valid = m_axis_tuser[0];
            got.side  = m_axis_tuser[1];
            got.qty   = m_axis_tdata[5:0];
            got.price = m_axis_tdata[21:6];
            if (orders_due.size() == 0)
            begin
                $error("order word with nothing expected: tuser %b tdata %h",
                       m_axis_tuser, m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = orders_due.pop_front();
                check_field("order_valid", want.valid, got.valid);
                check_field("order_side", want.side, got.side);
                check_field("order_quantity", want.qty, got.qty);
                check_field("order_price_cents", want.price, got.price);
            end
        end
        // hold ready low about 31 percent of the time while gaps are on
        m_axis_tready <= sink_gaps ? ($urandom_range(99) >= 31) : 1'b1;
    end

    // hard stop if the sizer hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Book source
    // ---------------------------------------------------------------------

    // Present one book word, hold it until taken, then log the order owed.
    task automatic send_book(input book_update_t bk, input logic typed, input order_t want);
        order_t predicted;
        while (src_gaps && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= bk.book_valid;
        s_axis_tdata  <= {bk.cash, bk.units, bk.ask, bk.bid};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = size_order(bk);
        orders_due.insert(orders_due.size(), typed ? want : predicted);
    endtask

    // Drop valid and hold until every owed order word has arrived.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (orders_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input damsz_pkg::cfg_index_t idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            damsz_pkg::CFG_THRESHOLD:  thr_q16    = val[15:0];
            damsz_pkg::CFG_INIT_UNITS: init_units = val;
            damsz_pkg::CFG_BUY_CAP:    buy_cap    = val[15:0];
            damsz_pkg::CFG_SELL_FLOOR: sell_floor = val[15:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic book_update_t mk_book(logic v, logic [15:0] bid, logic [15:0] ask,
                                             logic [23:0] units, logic [39:0] cash);
        book_update_t bk;
        bk.book_valid = v;
        bk.bid        = bid;
        bk.ask        = ask;
        bk.units      = units;
        bk.cash       = cash;
        return bk;
    endfunction

    function automatic order_t mk_order(logic side, logic [5:0] qty, logic [15:0] price);
        order_t o;
        o.valid = 1'b1;
        o.side  = side;
        o.qty   = qty;
        o.price = price;
        return o;
    endfunction

    script_row_t script [$];

    function automatic void add_row(logic cfg_en, damsz_pkg::cfg_index_t idx,
                                    logic [23:0] val, book_update_t bk, int reps,
                                    logic typed, order_t want);
        script_row_t r;
        r.cfg_en  = cfg_en;
        r.cfg_idx = idx;
        r.cfg_val = val;
        r.bk      = bk;
        r.reps    = reps;
        r.typed   = typed;
        r.want    = want;
        script.insert(script.size(), r);
    endfunction

    // Random register value with the extremes weighted in.
    function automatic logic [23:0] pick_reg(damsz_pkg::cfg_index_t idx);
        logic [23:0] v;
        int          r;
        r = $urandom_range(9);
        v = 24'($urandom);
        case (idx)
            damsz_pkg::CFG_THRESHOLD:
                v[15:0] = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd0 :
                          16'($urandom_range(3000, 40));
            damsz_pkg::CFG_INIT_UNITS:
                v = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF : (r == 2) ? v :
                    24'($urandom_range(5000));
            default:
                v[15:0] = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        endcase
        return v;   // upper bits of the 16-bit registers stay random
    endfunction

    // Next random book word: mostly a trending walk of the mid, with
    // invalid books, noise prices and price extremes mixed in.
    function automatic book_update_t next_book();
        book_update_t bk;
        logic [63:0]  wide;
        longint       hold;
        int           spread;
        int           r;
        wide = {$urandom, $urandom};
        bk.book_valid = 1'b1;
        bk.bid = 16'($urandom);
        bk.ask = 16'($urandom);
        r = $urandom_range(99);
        if (r < 8)
            bk.book_valid = 1'b0;
        else if (r < 15)
        begin
            bk.bid = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            bk.ask = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        else if (r >= 20)
        begin
            if (drift_left == 0)
            begin
                drift      = $urandom_range(80) - 40;
                drift_left = $urandom_range(60, 8);
                if ($urandom_range(9) == 0)
                    walk_mid = $urandom_range(65000, 200);
            end
            drift_left--;
            walk_mid += drift + $urandom_range(20) - 10;
            if (walk_mid < 100)
                walk_mid = 100;
            if (walk_mid > 65400)
                walk_mid = 65400;
            spread = $urandom_range(60);
            bk.bid = 16'(walk_mid - spread / 2);
            bk.ask = 16'(walk_mid + spread - spread / 2);
        end
        // hold near the reference most of the time so trades stay small
        r = $urandom_range(19);
        if (r < 14)
        begin
            hold = longint'(init_units) + $urandom_range(520) - 260;
            if (hold < 0)
                hold = 0;
            if (hold > 24'hFFFFFF)
                hold = 24'hFFFFFF;
            bk.units = 24'(hold);
        end
        else if (r == 14)
            bk.units = '0;
        else if (r == 15)
            bk.units = '1;
        else
            bk.units = wide[63:40];
        r = $urandom_range(9);
        if (r < 4)
            bk.cash = wide[39:0];
        else if (r < 7)
        begin
            // land right on the strict cash limit
            hold = longint'($urandom_range(50, 10)) * buy_cap + $urandom_range(2) - 1;
            bk.cash = (hold < 0) ? 40'd0 : 40'(hold);
        end
        else if (r == 7)
            bk.cash = '0;
        else if (r == 8)
            bk.cash = '1;
        else
            bk.cash = 40'($urandom_range(100000));
        return bk;
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        book_update_t          bk;
        int                    sent;
        damsz_pkg::cfg_index_t idx;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: threshold 328, reference 0, cap 12000, floor 10000
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(0, 16'hFFFF, 16'hFFFF, '1, '1),
                1, 1, NO_ORDER);
        // fill both windows with zero mids; no order until full
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 0, 0, 0, 0), 63, 1, NO_ORDER);
        // zero long average: target zero, sell the 30 units held
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 0, 0, 30, 0), 1, 1,
                mk_order(damsz_pkg::SIDE_SELL, 30, 16'd10000));
        // trade under the minimum is suppressed
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 0, 0, 9, 0), 1, 1, NO_ORDER);
        // large position clamps the sell to 50
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 0, 0, 1000, 0), 1, 1,
                mk_order(damsz_pkg::SIDE_SELL, 50, 16'd10000));
        // jump to the top price: strong upward divergence
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'hFFFF, 16'hFFFF, 0, '1),
                10, 0, NO_ORDER);
        // buy wanted but no cash at all
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'hFFFF, 16'hFFFF, 0, 0),
                1, 1, NO_ORDER);
        // cash exactly equal to 50 at the cap, then one cent more
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'hFFFF, 16'hFFFF, 0, 600000),
                1, 0, NO_ORDER);
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'hFFFF, 16'hFFFF, 0, 600001),
                1, 0, NO_ORDER);
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'hFFFF, 16'hFFFF, 1000, 0),
                1, 0, NO_ORDER);
        // invalid book mid-run leaves the windows alone
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(0, 16'h1234, 16'h5678, 77, 99),
                1, 1, NO_ORDER);
        // threshold zero: any divergence saturates
        add_row(1, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'h8000, 16'h8000, 0, '1),
                1, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_THRESHOLD, 16'hFFFF, mk_book(1, 0, 0, 0, '1),
                4, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_INIT_UNITS, 24'hFFFFFF, mk_book(1, 0, 0, '1, '1),
                1, 0, NO_ORDER);
        add_row(0, damsz_pkg::CFG_THRESHOLD, 0, mk_book(1, 16'hFFFF, 0, 0, '1),
                1, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_BUY_CAP, 0, mk_book(1, 100, 200, 24'hFFFFF0, 1),
                2, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_SELL_FLOOR, 16'hFFFF, mk_book(1, 0, 0, 5, 0),
                1, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_THRESHOLD, 1, mk_book(1, 16'h7FFF, 16'h8000, '1, '1),
                2, 0, NO_ORDER);
        // sell wanted but too few units held
        add_row(1, damsz_pkg::CFG_INIT_UNITS, 0, mk_book(1, 500, 500, 5, '1),
                1, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_THRESHOLD, damsz_pkg::THRESHOLD_RST,
                mk_book(1, 0, 0, 0, 0), 0, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_BUY_CAP, damsz_pkg::BUY_CAP_RST,
                mk_book(1, 0, 0, 0, 0), 0, 0, NO_ORDER);
        add_row(1, damsz_pkg::CFG_SELL_FLOOR, damsz_pkg::SELL_FLOOR_RST,
                mk_book(1, 0, 0, 0, 0), 0, 0, NO_ORDER);

        foreach (script[i])
        begin
            if (script[i].cfg_en)
            begin
                wait_idle();
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            end
            repeat (script[i].reps)
                send_book(script[i].bk, script[i].typed, script[i].want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            for (int k = 0; k < 4; k++)
            begin
                idx = damsz_pkg::cfg_index_t'(k);
                write_reg(idx, (ph == PHASES - 1) && (idx == damsz_pkg::CFG_THRESHOLD) ?
                               24'(damsz_pkg::THRESHOLD_RST) : pick_reg(idx));
            end
            // one phase runs flat out on both sides
            src_gaps  = (ph != 3);
            sink_gaps = (ph != 3);
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                bk = next_book();
                send_book(bk, 1'b0, NO_ORDER);
                if (bk.book_valid)
                    sent++;
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/damsz_pkg.sv
sv/damsz_ctrl.sv
sv/damsz_dp.sv
sv/dual_average_momentum_sizer.sv
sv/damsz_chk.sv
tb/tb_top.sv
